>>> rtl/magma_block_cipher_macros.svh
// Assertion helpers for the cipher RTL; magma_skid includes them.
// Each expects clk and rst_n in the scope of the module that uses it.
`ifndef MAGMA_BLOCK_CIPHER_MACROS_SVH
`define MAGMA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define MAGMA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("magma: same-cycle check failed");

// Next-cycle implication, quiet while in reset
`define MAGMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("magma: next-cycle check failed");

`endif

>>> rtl/magma_pkg.sv
`timescale 1ns / 1ps

package magma_pkg;

  localparam int ROUNDS    = 32;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int HALF_W    = 32;
  localparam int BLOCK_W   = 2 * HALF_W;
  localparam int KEY_WORDS = 8;
  localparam int KSEL_W    = $clog2(KEY_WORDS);
  localparam int CFG_IDX_W = $clog2(KEY_WORDS);
  localparam int ROT_L     = 11;
  localparam int NIB_CNT   = HALF_W / 4;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Fixed substitution boxes, box n serves nibble n
  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
      4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
      4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
    '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
      4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
    '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
      4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
    '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
      4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
    '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
      4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
    '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
      4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
  };

  typedef logic [KEY_WORDS-1:0][HALF_W-1:0] key_set_t;

  // One pipeline stage: valid travels with direction and both halves
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } stage_t;

  // Run every nibble through its own box
  function automatic logic [HALF_W-1:0] substitute(input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] r;
    r = '0;
    for (int n = 0; n < NIB_CNT; n++) begin
      r[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return r;
  endfunction

  // Key word used by round r for the given direction
  function automatic logic [KSEL_W-1:0] key_index(input logic [RND_W-1:0] r,
                                                  input logic op);
    logic [KSEL_W-1:0] fwd;
    logic [KSEL_W-1:0] rev;
    fwd = r[KSEL_W-1:0];
    rev = ~r[KSEL_W-1:0];
    if (op == OP_ENCRYPT) begin
      return (r < RND_W'(ROUNDS - KEY_WORDS)) ? fwd : rev;
    end
    return (r < RND_W'(KEY_WORDS)) ? fwd : rev;
  endfunction

endpackage

>>> rtl/magma_if.sv
`timescale 1ns / 1ps

// Input word: direction and plain block
interface magma_in_if;
  import magma_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [BLOCK_W-1:0] data_block;

  modport source (output valid, output operation, output data_block, input ready);
  modport sink   (input valid, input operation, input data_block, output ready);
endinterface

// Result word: processed block
interface magma_out_if;
  import magma_pkg::*;
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] out_block;

  modport source (output valid, output out_block, input ready);
  modport sink   (input valid, input out_block, output ready);
endinterface

>>> rtl/magma_keys.sv
`timescale 1ns / 1ps

module magma_keys
  import magma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  output key_set_t             keys
);

  key_set_t keys_r;

  // Write one key word per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_we) begin
      keys_r[cfg_index] <= cfg_data;
    end
  end

  assign keys = keys_r;

endmodule

>>> rtl/magma_round.sv
`timescale 1ns / 1ps

module magma_round
  import magma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [RND_W-1:0] round_idx,
  input  key_set_t         keys,
  input  stage_t           stg_in,
  output stage_t           stg_out
);

  logic [HALF_W-1:0] sum;
  logic [HALF_W-1:0] sub;
  logic [HALF_W-1:0] mixed;
  logic              last;
  stage_t            stg_nxt;
  stage_t            stg_r;

  // Add round key, substitute, rotate left
  always_comb begin
    sum   = stg_in.lo + keys[key_index(round_idx, stg_in.op)];
    sub   = substitute(sum);
    mixed = {sub[HALF_W-ROT_L-1:0], sub[HALF_W-1:HALF_W-ROT_L]};
    last  = (round_idx == RND_W'(ROUNDS - 1));
  end

  // Swap halves except on the final round
  always_comb begin
    stg_nxt.valid = stg_in.valid;
    stg_nxt.op    = stg_in.op;
    if (last) begin
      stg_nxt.hi = stg_in.hi ^ mixed;
      stg_nxt.lo = stg_in.lo;
    end else begin
      stg_nxt.hi = stg_in.lo;
      stg_nxt.lo = stg_in.hi ^ mixed;
    end
  end

  // Hold the stage while the pipe is frozen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (advance) begin
      stg_r.valid <= stg_nxt.valid;
    end
    if (advance) begin
      stg_r.op <= stg_nxt.op;
      stg_r.hi <= stg_nxt.hi;
      stg_r.lo <= stg_nxt.lo;
    end
  end

  assign stg_out = stg_r;

endmodule

>>> rtl/magma_skid.sv
`timescale 1ns / 1ps
`include "magma_block_cipher_macros.svh"

module magma_skid
  import magma_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  stage_t             last,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BLOCK_W-1:0] out_block
);

  logic               full_r;
  logic               full_nxt;
  logic [BLOCK_W-1:0] skid_r;
  logic               capture;

  // Park a word that the receiver did not take
  assign capture  = !full_r && last.valid && !out_ready;
  assign advance  = !full_r;

  always_comb begin
    if (full_r) begin
      full_nxt = !out_ready;
    end else begin
      full_nxt = capture;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      skid_r <= {last.hi, last.lo};
    end
  end

  // Drive the result from the skid slot first
  assign out_valid = full_r || last.valid;
  assign out_block = full_r ? skid_r : {last.hi, last.lo};

  `MAGMA_ASSERT_NEXT(a_skid_fill, capture, full_r && (skid_r == $past({last.hi, last.lo})))
  `MAGMA_ASSERT_NEXT(a_skid_hold, full_r && !out_ready, full_r && $stable(skid_r))
  `MAGMA_ASSERT_NEXT(a_skid_drain, full_r && out_ready, !full_r)

endmodule

>>> rtl/magma_block_cipher.sv
`timescale 1ns / 1ps
// GOST Magma block cipher engine, 64-bit block, 256-bit key.
// Input channel in_ch carries operation (0 encrypt, 1 decrypt) and data_block;
// result channel out_ch carries out_block. Both use valid/ready; a word moves
// at a rising clk edge with valid and ready high. Bytes are little-endian:
// the low half of the block is bytes 0 to 3.
// Key words 0..7 are written through cfg_we/cfg_index/cfg_data, effective at
// the next edge; write them only while no block is in flight (not enforced).
// Throughput: one block per cycle while the skid slot is empty.
// Each of the 32 rounds owns one register stage (one 32-bit add, the S-boxes
// and an XOR), and a block passes all of them before it shows on out_ch.
// When out_ch stalls, the word on it drops into a one-entry skid slot and the
// round pipeline still accepts a word in that cycle; with the slot full the
// whole pipeline freezes and in_ch.ready goes low, losing nothing.
// in_ch.ready comes straight from the skid flag register.
// Reset (rst_n low, synchronous) clears all key words to zero and empties the
// pipeline and the skid slot.

module magma_block_cipher
  import magma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  magma_in_if.sink             in_ch,
  magma_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data
);

  key_set_t keys;
  logic     advance;
  stage_t   stg [ROUNDS+1];

  magma_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // Split the accepted word into halves
  assign in_ch.ready  = advance;
  assign stg[0].valid = in_ch.valid && advance;
  assign stg[0].op    = in_ch.operation;
  assign stg[0].hi    = in_ch.data_block[BLOCK_W-1:HALF_W];
  assign stg[0].lo    = in_ch.data_block[HALF_W-1:0];

  // One round per stage
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    magma_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .round_idx (RND_W'(g)),
      .keys      (keys),
      .stg_in    (stg[g]),
      .stg_out   (stg[g+1])
    );
  end

  magma_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .last      (stg[ROUNDS]),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_block (out_ch.out_block)
  );

endmodule

>>> dv/magma_block_cipher_tb.sv
`timescale 1ns / 1ps

module magma_block_cipher_tb;
  import magma_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * ROUNDS + 8;
  localparam int MAX_REPORTS    = 10;

  // Substitution table, box n serves nibble n
  localparam logic [3:0] SUB_TABLE [8][16] = '{
    '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
      4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
      4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
    '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
      4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
    '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
      4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
    '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
      4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
    '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
      4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
    '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
      4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HALF_W-1:0]    cfg_data;

  magma_in_if  in_bus ();
  magma_out_if out_bus ();

  magma_block_cipher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the key words and the blocks still owed by the engine
  logic [HALF_W-1:0]  key_mirror [KEY_WORDS];
  logic [BLOCK_W-1:0] owed_blocks [$];
  int                 gap_pct;
  int                 stall_pct;
  int                 error_count;
  int                 idle_cycles;

  wire in_fire  = in_bus.valid && in_bus.ready;
  wire out_fire = out_bus.valid && out_bus.ready;

  // Free-running clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Add the round key, substitute every nibble, rotate left by 11
  function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] rk);
    logic [HALF_W-1:0] sum;
    logic [HALF_W-1:0] subst;
    sum = half + rk;
    for (int n = 0; n < 8; n++) begin
      subst[4*n +: 4] = SUB_TABLE[n][sum[4*n +: 4]];
    end
    return {subst[20:0], subst[31:21]};
  endfunction

  // Key word that feeds round rnd in the given direction
  function automatic int unsigned round_key_slot(input int unsigned rnd, input logic op);
    if (op == OP_ENCRYPT) begin
      return (rnd < 24) ? (rnd % 8) : (31 - rnd);
    end
    return (rnd < 8) ? rnd : (7 - (rnd % 8));
  endfunction

  // Full 32-round Feistel pass, no swap after the last round
  function automatic logic [BLOCK_W-1:0] magma_crypt(input logic op,
                                                     input logic [BLOCK_W-1:0] blk);
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] nlo;
    lo = blk[31:0];
    hi = blk[63:32];
    for (int unsigned r = 0; r < ROUNDS - 1; r++) begin
      nlo = hi ^ round_mix(lo, key_mirror[round_key_slot(r, op)]);
      hi  = lo;
      lo  = nlo;
    end
    hi = hi ^ round_mix(lo, key_mirror[round_key_slot(ROUNDS - 1, op)]);
    return {hi, lo};
  endfunction

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Predict each accepted word and check each result word against the oldest
  always @(posedge clk) begin
    logic [BLOCK_W-1:0] want;
    if (rst_n) begin
      if (in_fire) begin
        owed_blocks.push_back(magma_crypt(in_bus.operation, in_bus.data_block));
      end
      if (out_fire) begin
        if (owed_blocks.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result word: out_block=%016h", out_bus.out_block);
          end
        end else begin
          want = owed_blocks.pop_front();
          if (out_bus.out_block !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("out_block mismatch: expected %016h, got %016h",
                       want, out_bus.out_block);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until it is taken
  task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
    while ($urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.data_block <= blk;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (owed_blocks.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  // Write the selected key words; the engine must be idle
  task automatic program_key(input logic [HALF_W-1:0] words [KEY_WORDS],
                             input logic [KEY_WORDS-1:0] sel);
    wait_drained();
    for (int i = 0; i < KEY_WORDS; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= words[i];
        @(posedge clk);
        key_mirror[i] = words[i];
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [HALF_W-1:0] random_key_word();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [BLOCK_W-1:0] random_block();
    int unsigned roll;
    roll = $urandom_range(31);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return {32'h0, $urandom};
    if (roll == 3) return {$urandom, 32'h0};
    return {$urandom, $urandom};
  endfunction

  task automatic load_random_key();
    logic [HALF_W-1:0] words [KEY_WORDS];
    for (int i = 0; i < KEY_WORDS; i++) begin
      words[i] = random_key_word();
    end
    program_key(words, '1);
  endtask

  // Key left at its reset value of zero
  task automatic test_reset_key();
    send_block(OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, '0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
  endtask

  // All-ones key forces the round-key add to wrap
  task automatic test_key_extremes();
    logic [HALF_W-1:0] words [KEY_WORDS];
    for (int i = 0; i < KEY_WORDS; i++) begin
      words[i] = '1;
    end
    program_key(words, '1);
    send_block(OP_ENCRYPT, 64'h0000_0000_0000_0001);
    send_block(OP_DECRYPT, 64'h8000_0000_0000_0000);
    send_block(OP_ENCRYPT, 64'h0000_0000_ffff_ffff);
    send_block(OP_DECRYPT, 64'hffff_ffff_0000_0000);
    send_block(OP_ENCRYPT, 64'haaaa_aaaa_5555_5555);
    send_block(OP_DECRYPT, 64'h5555_5555_aaaa_aaaa);
  endtask

  // Distinct key words so a wrong key schedule shows up
  task automatic test_distinct_key();
    logic [HALF_W-1:0] words [KEY_WORDS];
    words = '{32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc,
              32'hf3f2f1f0, 32'hf7f6f5f4, 32'hfbfaf9f8, 32'hfffefdfc};
    program_key(words, '1);
    send_block(OP_ENCRYPT, 64'hfedcba98_76543210);
    send_block(OP_DECRYPT, 64'h4ee901e5_c2d8ca3d);
  endtask

  // Rewrite one word only; the others must keep their value
  task automatic test_single_word();
    logic [HALF_W-1:0] words [KEY_WORDS];
    words = key_mirror;
    words[5] = 32'h0123_4567;
    program_key(words, 8'b0010_0000);
    send_block(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
    send_block(OP_DECRYPT, 64'h0123_4567_89ab_cdef);
  endtask

  // Feed each direction the output of the other
  task automatic test_round_trip();
    logic [BLOCK_W-1:0] plain;
    load_random_key();
    plain = {$urandom, $urandom};
    send_block(OP_ENCRYPT, plain);
    send_block(OP_DECRYPT, magma_crypt(OP_ENCRYPT, plain));
    plain = {$urandom, $urandom};
    send_block(OP_DECRYPT, plain);
    send_block(OP_ENCRYPT, magma_crypt(OP_DECRYPT, plain));
  endtask

  // Random words under a fresh key for each idling phase
  task automatic test_random_traffic();
    int gaps   [4] = '{0, 70, 0, 27};
    int stalls [4] = '{0, 0, 70, 27};
    int count;
    count = 400;
    for (int p = 0; p < 4; p++) begin
      load_random_key();
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      for (int i = 0; i < count; i++) begin
        // Hold off once in mid-phase until the engine is empty
        if (p == 2 && i == count / 2) begin
          wait_drained();
        end
        send_block(logic'($urandom_range(1)), random_block());
      end
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  // Drive all inputs, reset, run the tests in turn, report
  initial begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      key_mirror[i] = '0;
    end
    error_count       = 0;
    gap_pct           = 0;
    stall_pct         = 0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_ENCRYPT;
    in_bus.data_block <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_distinct_key();
    test_single_word();
    test_round_trip();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && owed_blocks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
